### src/fplw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplw_pkg
// Shared types, codes and helper functions of the fixed-point line walker.
// ----------------------------------------------------------------------------
package fplw_pkg;

    localparam int COORD_W = 8;
    localparam int FRAC_W  = 16;
    localparam int POS_W   = COORD_W + FRAC_W;
    localparam int INC_W   = 18;
    localparam int QUO_W   = 17;
    localparam int DIR_W   = 2;
    localparam int END_W   = 3;
    localparam int PH_W    = 3;
    localparam int FUNC_W  = 2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    localparam int QUEUE_DEPTH = 2;

    // Command codes carried in the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PLACE = 2'd0,
        FUNC_WALK  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // Facing and heading codes
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;
    localparam logic [END_W-1:0] DIR_NONE  = 3'd4;

    // Walk phases
    localparam logic [PH_W-1:0] PH_STOPPED  = 3'd0;
    localparam logic [PH_W-1:0] PH_STARTING = 3'd1;
    localparam logic [PH_W-1:0] PH_WALKING  = 3'd2;
    localparam logic [PH_W-1:0] PH_STOPPING = 3'd3;
    localparam logic [PH_W-1:0] PH_FINISHED = 3'd4;

    localparam logic signed [INC_W-1:0] UNIT_STEP = 18'sh10000;

    typedef struct packed {
        t_func                func;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [END_W-1:0]     end_dir;
    } t_cmd;

    // Full unit step with the given sign
    function automatic logic signed [INC_W-1:0] unit_step(input logic neg);
        unit_step = neg ? -UNIT_STEP : UNIT_STEP;
    endfunction

    // Quarter turn used when the wanted heading is behind the current facing
    function automatic logic [DIR_W-1:0] quarter_turn(input logic [DIR_W-1:0] face);
        logic [DIR_W-1:0] res;
        case (face)
            DIR_LEFT:  res = DIR_DOWN;
            DIR_RIGHT: res = DIR_DOWN;
            DIR_DOWN:  res = DIR_RIGHT;
            default:   res = DIR_LEFT;
        endcase
        quarter_turn = res;
    endfunction

    // One turning step of the facing toward a heading
    function automatic logic [DIR_W-1:0] turn_toward(input logic [DIR_W-1:0] move,
                                                     input logic [DIR_W-1:0] face);
        turn_toward = (move == (face ^ 2'd1)) ? quarter_turn(face) : move;
    endfunction

endpackage
`default_nettype wire

### src/fplw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplw_front
// Input stage: takes a command transaction, decodes it and hands it on.
// ----------------------------------------------------------------------------
module fplw_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [fplw_pkg::IN_DATA_W-1:0] i_data,
    input  wire logic [fplw_pkg::FUNC_W-1:0]   i_user,
    output logic                               o_cmd_valid,
    input  wire logic                          i_cmd_ready,
    output fplw_pkg::t_cmd                     o_cmd
);

    logic           r_valid;
    fplw_pkg::t_cmd r_cmd;
    fplw_pkg::t_cmd n_cmd;
    logic [fplw_pkg::END_W-1:0] w_end;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Out-of-range final facing means no final turn
    always_comb begin
        w_end = i_data[18:16];
        if (w_end > fplw_pkg::DIR_NONE) begin
            w_end = fplw_pkg::DIR_NONE;
        end
        n_cmd.func    = fplw_pkg::t_func'(i_user);
        n_cmd.x       = i_data[7:0];
        n_cmd.y       = i_data[15:8];
        n_cmd.end_dir = w_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

### src/fplw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplw_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module fplw_queue #(
    parameter int DEPTH = fplw_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_ready,
    input  wire fplw_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_pop,
    output fplw_pkg::t_cmd      o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fplw_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

### src/fplw_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplw_div
// Restoring divider: quotient of num * 65536 / den for num <= den, one bit
// per cycle.
// ----------------------------------------------------------------------------
module fplw_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [fplw_pkg::COORD_W-1:0]    i_num,
    input  wire logic [fplw_pkg::COORD_W-1:0]    i_den,
    output logic                                 o_done,
    output logic [fplw_pkg::QUO_W-1:0]           o_quo
);

    localparam int CNT_W = $clog2(fplw_pkg::QUO_W + 1);
    localparam int REM_W = fplw_pkg::COORD_W + 1;

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [REM_W-1:0]              r_rem;
    logic [fplw_pkg::COORD_W-1:0]  r_den;
    logic [fplw_pkg::QUO_W-1:0]    r_quo;
    logic                          w_ge;
    logic [REM_W-1:0]              w_diff;
    logic [fplw_pkg::COORD_W-1:0]  w_rem_low;

    assign o_done = r_done;
    assign o_quo  = r_quo;

    // Remainder stays below the divisor, so its low bits hold it exactly
    always_comb begin
        w_ge      = (r_rem >= {1'b0, r_den});
        w_diff    = r_rem - {1'b0, r_den};
        w_rem_low = w_ge ? w_diff[fplw_pkg::COORD_W-1:0] : r_rem[fplw_pkg::COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(fplw_pkg::QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[fplw_pkg::QUO_W-2:0], w_ge};
            r_rem <= {w_rem_low, 1'b0};
        end
    end

endmodule
`default_nettype wire

### src/fplw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fplw_back
// Execution part: walker state, tick and walk sequencing, output register.
// ----------------------------------------------------------------------------
module fplw_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cmd_valid,
    output logic                                   o_pop,
    input  wire fplw_pkg::t_cmd                    i_cmd,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [fplw_pkg::OUT_DATA_W-1:0]        o_data
);

    localparam int CW = fplw_pkg::COORD_W;
    localparam int FW = fplw_pkg::FRAC_W;
    localparam int PW = fplw_pkg::POS_W;
    localparam int IW = fplw_pkg::INC_W;
    localparam int DW = fplw_pkg::DIR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_OUT
    } t_state;

    t_state                        r_state;
    fplw_pkg::t_cmd                r_cmd;
    logic [CW-1:0]                 r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic [FW-1:0]                 r_part_x, r_part_y;
    logic signed [IW-1:0]          r_inc_x, r_inc_y;
    logic [DW-1:0]                 r_move, r_face;
    logic [fplw_pkg::PH_W-1:0]     r_phase;
    logic [fplw_pkg::END_W-1:0]    r_end;
    logic                          r_div_to_y;
    logic                          r_div_neg;
    logic                          r_out_valid;
    logic [fplw_pkg::OUT_DATA_W-1:0] r_out_data;

    // Tick results
    logic [CW-1:0]                 t_x, t_y;
    logic [FW-1:0]                 t_part_x, t_part_y;
    logic signed [IW-1:0]          t_inc_x, t_inc_y;
    logic [DW-1:0]                 t_move, t_face;
    logic [fplw_pkg::PH_W-1:0]     t_phase;
    logic [CW-1:0]                 t_sx, t_sy;
    logic                          t_has_end;
    logic [PW-1:0]                 t_vx, t_vy;

    // Walk set-up results
    logic [CW-1:0]                 w_dx, w_dy, w_ax, w_ay;
    logic                          w_neg_x, w_neg_y, w_same, w_need_div;
    logic [DW-1:0]                 w_move;
    logic [CW-1:0]                 w_num, w_den;

    logic                          w_div_start;
    logic                          w_div_done;
    logic [fplw_pkg::QUO_W-1:0]    w_quo;
    logic signed [IW-1:0]          w_quo_inc;

    assign o_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    fplw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_div_start = (r_state == S_DECODE) && (r_cmd.func == fplw_pkg::FUNC_WALK)
                         && !w_same && w_need_div;
    assign w_quo_inc   = r_div_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    // Walk: direction, magnitudes and the divider operands
    always_comb begin
        w_dx       = r_cmd.x - r_cur_x;
        w_dy       = r_cmd.y - r_cur_y;
        w_neg_x    = w_dx[CW-1];
        w_neg_y    = w_dy[CW-1];
        w_ax       = w_neg_x ? (~w_dx + CW'(1)) : w_dx;
        w_ay       = w_neg_y ? (~w_dy + CW'(1)) : w_dy;
        w_same     = (w_dx == '0) && (w_dy == '0);
        w_need_div = (w_dx != '0) && (w_dy != '0);
        if (w_ax < w_ay) begin
            w_move = w_neg_y ? fplw_pkg::DIR_UP : fplw_pkg::DIR_DOWN;
        end else begin
            w_move = w_neg_x ? fplw_pkg::DIR_LEFT : fplw_pkg::DIR_RIGHT;
        end
        if (w_ax > w_ay) begin
            w_num = w_ay;
            w_den = w_ax;
        end else begin
            w_num = w_ax;
            w_den = w_ay;
        end
    end

    // Tick: snap, arrival sequence, turn, advance
    always_comb begin
        t_x       = r_cur_x;
        t_y       = r_cur_y;
        t_part_x  = r_part_x;
        t_part_y  = r_part_y;
        t_inc_x   = r_inc_x;
        t_inc_y   = r_inc_y;
        t_move    = r_move;
        t_face    = r_face;
        t_phase   = r_phase;
        t_has_end = (r_end != fplw_pkg::DIR_NONE);
        t_sx      = r_cur_x;
        t_sy      = r_cur_y;
        t_vx      = '0;
        t_vy      = '0;
        if (!r_move[1] && r_cur_x == r_goal_x) begin
            t_sy = r_goal_y;
        end else if (r_move[1] && r_cur_y == r_goal_y) begin
            t_sx = r_goal_x;
        end
        if (r_phase != fplw_pkg::PH_STOPPED) begin
            t_x = t_sx;
            t_y = t_sy;
            if (t_sx == r_goal_x && t_sy == r_goal_y) begin
                t_inc_x = '0;
                t_inc_y = '0;
                if (r_phase != fplw_pkg::PH_STOPPING && r_phase != fplw_pkg::PH_FINISHED) begin
                    t_phase  = fplw_pkg::PH_STOPPING;
                    t_part_x = '0;
                    t_part_y = '0;
                end else begin
                    if (t_has_end && r_end[DW-1:0] != r_face) begin
                        t_move = r_end[DW-1:0];
                        t_face = fplw_pkg::turn_toward(r_end[DW-1:0], r_face);
                    end
                    if (r_phase == fplw_pkg::PH_STOPPING
                        && (!t_has_end || r_end[DW-1:0] == t_face)) begin
                        t_phase = fplw_pkg::PH_FINISHED;
                    end else if (r_phase == fplw_pkg::PH_FINISHED) begin
                        t_phase = fplw_pkg::PH_STOPPED;
                    end
                end
            end else begin
                if (r_phase == fplw_pkg::PH_STARTING) begin
                    t_phase = fplw_pkg::PH_WALKING;
                end else if (r_move != r_face) begin
                    t_face = fplw_pkg::turn_toward(r_move, r_face);
                end
                if (r_move == t_face) begin
                    t_vx     = {t_sx, r_part_x} + PW'(r_inc_x);
                    t_vy     = {t_sy, r_part_y} + PW'(r_inc_y);
                    t_x      = t_vx[PW-1:FW];
                    t_part_x = t_vx[FW-1:0];
                    t_y      = t_vy[PW-1:FW];
                    t_part_y = t_vy[FW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_part_x    <= '0;
            r_part_y    <= '0;
            r_inc_x     <= '0;
            r_inc_y     <= '0;
            r_move      <= fplw_pkg::DIR_LEFT;
            r_face      <= fplw_pkg::DIR_LEFT;
            r_phase     <= fplw_pkg::PH_STOPPED;
            r_end       <= fplw_pkg::DIR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_out_valid && i_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_state <= S_OUT;
                    unique case (r_cmd.func)
                        fplw_pkg::FUNC_PLACE: begin
                            r_cur_x  <= r_cmd.x;
                            r_cur_y  <= r_cmd.y;
                            r_goal_x <= r_cmd.x;
                            r_goal_y <= r_cmd.y;
                            r_part_x <= '0;
                            r_part_y <= '0;
                            r_inc_x  <= '0;
                            r_inc_y  <= '0;
                            r_phase  <= fplw_pkg::PH_STOPPED;
                        end
                        fplw_pkg::FUNC_WALK: begin
                            r_part_x <= '0;
                            r_part_y <= '0;
                            r_goal_x <= r_cmd.x;
                            r_goal_y <= r_cmd.y;
                            r_end    <= r_cmd.end_dir;
                            if (w_same) begin
                                r_phase <= fplw_pkg::PH_STOPPED;
                                if (r_cmd.end_dir != fplw_pkg::DIR_NONE) begin
                                    r_face <= r_cmd.end_dir[DW-1:0];
                                end
                            end else begin
                                if (r_phase != fplw_pkg::PH_WALKING) begin
                                    r_phase <= fplw_pkg::PH_STARTING;
                                end
                                r_move <= w_move;
                                if (w_dx == '0) begin
                                    r_inc_x <= '0;
                                    r_inc_y <= fplw_pkg::unit_step(w_neg_y);
                                end else if (w_dy == '0) begin
                                    r_inc_x <= fplw_pkg::unit_step(w_neg_x);
                                    r_inc_y <= '0;
                                end else if (w_ax > w_ay) begin
                                    r_inc_x    <= fplw_pkg::unit_step(w_neg_x);
                                    r_div_to_y <= 1'b1;
                                    r_div_neg  <= w_neg_y;
                                    r_state    <= S_DIV;
                                end else begin
                                    r_inc_y    <= fplw_pkg::unit_step(w_neg_y);
                                    r_div_to_y <= 1'b0;
                                    r_div_neg  <= w_neg_x;
                                    r_state    <= S_DIV;
                                end
                            end
                        end
                        fplw_pkg::FUNC_TICK: begin
                            r_cur_x  <= t_x;
                            r_cur_y  <= t_y;
                            r_part_x <= t_part_x;
                            r_part_y <= t_part_y;
                            r_inc_x  <= t_inc_x;
                            r_inc_y  <= t_inc_y;
                            r_move   <= t_move;
                            r_face   <= t_face;
                            r_phase  <= t_phase;
                        end
                        default: begin
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_div_to_y) begin
                            r_inc_y <= w_quo_inc;
                        end else begin
                            r_inc_x <= w_quo_inc;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {1'b0, r_phase, r_move, r_face,
                                        r_part_y, r_part_x, r_cur_y, r_cur_x};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### src/fixed_point_line_walker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_line_walker_unit
// Steps a point toward a target along a straight line in 8.16 fixed point.
// ----------------------------------------------------------------------------
// Each command transaction on the slave side (place, walk, tick or no-op,
// chosen by tuser) produces exactly one status transaction on the master side
// with the position, fractions, facing, heading and walk phase after the
// command. A front stage registers and decodes commands and pushes them into a
// short queue; the back part pops one command at a time, updates the walker
// state and loads the result into an output register, so new commands keep
// flowing into the queue while a result waits to be taken. Place, tick, no-op
// and axis-aligned walks pass only through the decode and output states; a walk
// whose line is not aligned with an axis also waits in the divide state for the
// restoring divider that forms the 17-bit minor-axis increment. A command
// passes the front register and then the queue, which offers it once stored.
// ----------------------------------------------------------------------------
module fixed_point_line_walker_unit #(
    parameter int QUEUE_DEPTH = fplw_pkg::QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Command stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: coord_x [7:0], coord_y [15:8], final_dir [18:16], zero [23:19]
    input  wire logic [fplw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: func [1:0]
    input  wire logic [fplw_pkg::FUNC_W-1:0]       s_axis_tuser,
    // Status stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: pos_x [7:0], pos_y [15:8], frac_x [31:16], frac_y [47:32],
    //        facing [49:48], heading [51:50], walk_phase [54:52], zero [55]
    output logic [fplw_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

    // Front-to-queue transaction
    logic           w_front_valid;
    logic           w_front_ready;
    fplw_pkg::t_cmd w_front_cmd;

    // Queue-to-back transaction
    logic           w_q_valid;
    logic           w_q_pop;
    fplw_pkg::t_cmd w_q_cmd;

    // Register, decode and clamp the incoming command
    fplw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd)
    );

    // Hold decoded commands while the back part is busy
    fplw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .o_ready (w_front_ready),
        .i_cmd   (w_front_cmd),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd)
    );

    // Execute one command at a time and drive the status stream
    fplw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_pop       (w_q_pop),
        .i_cmd       (w_q_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

endmodule
`default_nettype wire
